>>> rtl/core/chfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chfb_pkg
// Shared constants, angle table and item type for the compass heading unit.
// ----------------------------------------------------------------------------
package chfb_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STAGES   = 16;

  localparam int TABLE_LEN = 24;
  localparam int NSTG      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int ACC_FRAC  = 20;
  localparam int SAMPLE_W  = 16;
  localparam int WORK_W    = 27;
  localparam int ACC_W     = 30;
  localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int H_W       = ACC_W - RND_SHIFT;
  localparam int HEAD_W    = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [ACC_W-1:0] ACC_POS90 = ACC_W'(90 * (2 ** ACC_FRAC));
  localparam logic signed [ACC_W-1:0] ACC_NEG90 = -ACC_POS90;
  localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(2 ** (RND_SHIFT - 1));
  localparam logic signed [31:0]      LIM_Q     = 32'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [31:0]      HEAD_MAX  = 32'(32767);
  localparam logic signed [31:0]      HEAD_MIN  = -32'sd32768;

  // round(atan(2^-i) in degrees * 2^20)
  localparam logic [25:0] ATAN_TAB [TABLE_LEN] = '{
    26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121, 26'd3750058, 26'd1876857,
    26'd938658,   26'd469357,   26'd234682,   26'd117342,  26'd58671,   26'd29335,
    26'd14668,    26'd7334,     26'd3667,     26'd1833,    26'd917,     26'd458,
    26'd229,      26'd115,      26'd57,       26'd29,      26'd14,      26'd7
  };

  typedef struct packed {
    logic signed [WORK_W-1:0] x;
    logic signed [WORK_W-1:0] z;
    logic signed [ACC_W-1:0]  acc;
    logic                     both_zero;
  } item_t;

endpackage
`default_nettype wire

>>> rtl/core/compass_heading_from_bytes_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: front register, queue, stage-0 and CORDIC stage registers, output register.
// Throughput: one transaction per cycle while out_stall is low; set by the unrolled CORDIC pipeline.
// A two-entry queue parts the front end from the pipeline, which halts as a
// whole while the output register is stalled.
// Reset: synchronous, active low; clears valid flags, queue pointers and queue count only.
// ----------------------------------------------------------------------------
// compass_heading_from_bytes_unit
// Heading atan2(Z, X) in degrees, Q7, from raw magnetometer byte pairs.
// ----------------------------------------------------------------------------
module compass_heading_from_bytes_unit import chfb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [7:0]        in_x_high_byte,
  input  wire logic [7:0]        in_x_low_byte,
  input  wire logic [7:0]        in_z_high_byte,
  input  wire logic [7:0]        in_z_low_byte,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [HEAD_W-1:0] out_heading_deg_q7,
  output      logic              out_both_zero
);

  logic  q_full;
  logic  q_push;
  item_t q_in_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_head;

  chfb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x_high_byte (in_x_high_byte),
    .in_x_low_byte  (in_x_low_byte),
    .in_z_high_byte (in_z_high_byte),
    .in_z_low_byte  (in_z_low_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in_item)
  );

  chfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  chfb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_heading_deg_q7 (out_heading_deg_q7),
    .out_both_zero      (out_both_zero)
  );

`ifndef SYNTHESIS
  a_zero_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_both_zero |-> out_heading_deg_q7 == '0)
    else $error("zero vector gave a non-zero heading");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'($signed(out_heading_deg_q7)) <= LIM_Q) &&
                  (32'($signed(out_heading_deg_q7)) >= -LIM_Q))
    else $error("heading outside +-180 degrees");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

>>> rtl/core/chfb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chfb_front
// Takes byte transactions, joins samples, flags zero vectors and turns the
// vector into the right half plane before it is queued.
// ----------------------------------------------------------------------------
module chfb_front import chfb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_x_high_byte,
  input  wire logic [7:0] in_x_low_byte,
  input  wire logic [7:0] in_z_high_byte,
  input  wire logic [7:0] in_z_low_byte,
  input  wire logic       q_full,
  output      logic       q_push,
  output      item_t      q_item
);

  logic                       valid_r;
  logic                       valid_nxt;
  item_t                      item_r;
  item_t                      item_nxt;
  logic                       accept;
  logic signed [SAMPLE_W-1:0] xs;
  logic signed [SAMPLE_W-1:0] zs;
  logic signed [WORK_W-1:0]   xw;
  logic signed [WORK_W-1:0]   zw;

  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = valid_r && !q_full;
  assign q_item   = item_r;

  always_comb begin
    xs = $signed({in_x_high_byte, in_x_low_byte});
    zs = $signed({in_z_high_byte, in_z_low_byte});
    xw = WORK_W'(xs) <<< 8;
    zw = WORK_W'(zs) <<< 8;
    item_nxt.both_zero = (xs == '0) && (zs == '0);
    if (xw < 0) begin
      if (zw >= 0) begin
        item_nxt.x   = zw;
        item_nxt.z   = -xw;
        item_nxt.acc = ACC_POS90;
      end else begin
        item_nxt.x   = -zw;
        item_nxt.z   = xw;
        item_nxt.acc = ACC_NEG90;
      end
    end else begin
      item_nxt.x   = xw;
      item_nxt.z   = zw;
      item_nxt.acc = '0;
    end
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/chfb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chfb_queue
// Short register queue between the front end and the CORDIC back end.
// ----------------------------------------------------------------------------
module chfb_queue import chfb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output      logic  full,
  input  wire logic  pop,
  output      logic  head_valid,
  output      item_t head_item
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/chfb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chfb_back
// Pipelined CORDIC in vectoring mode, one micro-rotation per stage, then
// rounding, clamping and the output register.
// ----------------------------------------------------------------------------
module chfb_back import chfb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire item_t             q_item,
  output      logic              q_pop,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic [HEAD_W-1:0] out_heading_deg_q7,
  output      logic              out_both_zero
);

  logic signed [WORK_W-1:0] x_r   [0:NSTG];
  logic signed [WORK_W-1:0] z_r   [0:NSTG];
  logic signed [ACC_W-1:0]  acc_r [0:NSTG];
  logic [NSTG:0]            zero_r;
  logic [NSTG:0]            v_r;
  logic                     en;

  logic                     out_valid_r;
  logic [HEAD_W-1:0]        heading_r;
  logic [HEAD_W-1:0]        heading_nxt;
  logic                     both_zero_r;

  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [H_W-1:0]    h;
  logic signed [31:0]       h_wide;
  logic signed [31:0]       h_clamp;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NSTG-1:0], q_valid};
      out_valid_r <= v_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= q_item.x;
      z_r[0]    <= q_item.z;
      acc_r[0]  <= q_item.acc;
      zero_r[0] <= q_item.both_zero;
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    logic signed [WORK_W-1:0] dx;
    logic signed [WORK_W-1:0] dz;
    logic signed [WORK_W-1:0] x_nxt;
    logic signed [WORK_W-1:0] z_nxt;
    logic signed [ACC_W-1:0]  acc_nxt;
    logic signed [ACC_W-1:0]  ang;

    assign dx  = z_r[k] >>> k;
    assign dz  = x_r[k] >>> k;
    assign ang = $signed(ACC_W'(ATAN_TAB[k]));

    always_comb begin
      if (!z_r[k][WORK_W-1]) begin
        x_nxt   = x_r[k] + dx;
        z_nxt   = z_r[k] - dz;
        acc_nxt = acc_r[k] + ang;
      end else begin
        x_nxt   = x_r[k] - dx;
        z_nxt   = z_r[k] + dz;
        acc_nxt = acc_r[k] - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1]    <= x_nxt;
        z_r[k+1]    <= z_nxt;
        acc_r[k+1]  <= acc_nxt;
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  always_comb begin
    acc_rnd = acc_r[NSTG] + ROUND_ADD;
    h       = $signed(acc_rnd[ACC_W-1:RND_SHIFT]);
    h_wide  = 32'(h);
    if (h_wide > LIM_Q) begin
      h_clamp = LIM_Q;
    end else if (h_wide < -LIM_Q) begin
      h_clamp = -LIM_Q;
    end else begin
      h_clamp = h_wide;
    end
    if (h_clamp > HEAD_MAX) begin
      h_clamp = HEAD_MAX;
    end else if (h_clamp < HEAD_MIN) begin
      h_clamp = HEAD_MIN;
    end
    heading_nxt = zero_r[NSTG] ? '0 : h_clamp[HEAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading_r   <= heading_nxt;
      both_zero_r <= zero_r[NSTG];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_heading_deg_q7 = heading_r;
  assign out_both_zero      = both_zero_r;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for compass_heading_from_bytes_unit. A short table of
// directed byte pairs (extremes, axis crossings, zero vector) is followed by
// random pairs under four idling phases on both channels. Every result is
// compared in order against a fixed table value or a bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
module testbench;
  import chfb_pkg::*;

  localparam int LATENCY          = CORDIC_STAGES + 3;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_PER_PHASE = 208;
  localparam int NUM_DIRECTED     = 21;
  localparam int MAX_PRINTS       = 50;
  localparam int ACC_FRAC_BITS    = 20;
  localparam int ATAN_ENTRIES     = 24;
  localparam int RUN_STAGES       = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                   : CORDIC_STAGES;

  typedef struct packed {
    logic [15:0] heading;
    logic        both_zero;
  } heading_res_t;

  typedef struct packed {
    logic [15:0]  x;
    logic [15:0]  z;
    logic         fixed;
    heading_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_x_high_byte;
  logic [7:0]  in_x_low_byte;
  logic [7:0]  in_z_high_byte;
  logic [7:0]  in_z_low_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_heading_deg_q7;
  logic        out_both_zero;

  logic         row_fixed;
  heading_res_t row_res;

  int idle_pct  = 0;
  int stall_pct = 0;
  int n_errors  = 0;
  int quiet_cnt = 0;

  heading_res_t pending_headings [$];

  int atan_q20 [0:ATAN_ENTRIES-1] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
  };

  dir_row_t dir_rows [0:NUM_DIRECTED-1] = '{
    '{16'h0000, 16'h0000, 1'b1, '{16'h0000, 1'b1}},
    '{16'h7FFF, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{16'h8000, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{16'hFFFF, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{16'h0001, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
    '{16'h0000, 16'h7FFF, 1'b0, '{16'h0000, 1'b0}},
    '{16'h0000, 16'h8000, 1'b0, '{16'h0000, 1'b0}},
    '{16'h0000, 16'h0001, 1'b0, '{16'h0000, 1'b0}},
    '{16'h0000, 16'hFFFF, 1'b0, '{16'h0000, 1'b0}},
    '{16'h7FFF, 16'h7FFF, 1'b0, '{16'h0000, 1'b0}},
    '{16'h8000, 16'h8000, 1'b0, '{16'h0000, 1'b0}},
    '{16'h8000, 16'h7FFF, 1'b0, '{16'h0000, 1'b0}},
    '{16'h7FFF, 16'h8000, 1'b0, '{16'h0000, 1'b0}},
    '{16'hFFFF, 16'hFFFF, 1'b0, '{16'h0000, 1'b0}},
    '{16'hFFFF, 16'h0001, 1'b0, '{16'h0000, 1'b0}},
    '{16'h0001, 16'hFFFF, 1'b0, '{16'h0000, 1'b0}},
    '{16'h00FF, 16'hFF00, 1'b0, '{16'h0000, 1'b0}},
    '{16'hFF00, 16'h00FF, 1'b0, '{16'h0000, 1'b0}},
    '{16'h0100, 16'h0080, 1'b0, '{16'h0000, 1'b0}},
    '{16'h8001, 16'h0001, 1'b0, '{16'h0000, 1'b0}},
    '{16'h0000, 16'h0000, 1'b1, '{16'h0000, 1'b1}}
  };

  compass_heading_from_bytes_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_x_high_byte     (in_x_high_byte),
    .in_x_low_byte      (in_x_low_byte),
    .in_z_high_byte     (in_z_high_byte),
    .in_z_low_byte      (in_z_low_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_heading_deg_q7 (out_heading_deg_q7),
    .out_both_zero      (out_both_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic heading_res_t predict_heading(input logic [15:0] xv,
                                                   input logic [15:0] zv);
    heading_res_t r;
    int xs;
    int zs;
    int x;
    int z;
    int t;
    int dx;
    int dz;
    int acc;
    int h;
    int lim;
    int shift;
    xs = $signed(xv);
    zs = $signed(zv);
    r.heading   = 16'h0000;
    r.both_zero = 1'b0;
    if (xs == 0 && zs == 0) begin
      r.both_zero = 1'b1;
      return r;
    end
    x   = xs * 256;
    z   = zs * 256;
    acc = 0;
    if (x < 0) begin
      t = x;
      if (z >= 0) begin
        x   = z;
        z   = -t;
        acc = 90 * (1 << ACC_FRAC_BITS);
      end else begin
        x   = -z;
        z   = t;
        acc = -90 * (1 << ACC_FRAC_BITS);
      end
    end
    for (int i = 0; i < RUN_STAGES; i++) begin
      dx = z >>> i;
      dz = x >>> i;
      if (z >= 0) begin
        x   = x + dx;
        z   = z - dz;
        acc = acc + atan_q20[i];
      end else begin
        x   = x - dx;
        z   = z + dz;
        acc = acc - atan_q20[i];
      end
    end
    shift = ACC_FRAC_BITS - ANGLE_FRAC_BITS;
    h     = (acc + (1 << (shift - 1))) >>> shift;
    lim   = 180 * (1 << ANGLE_FRAC_BITS);
    if (h > lim) h = -(-lim);
    if (h > lim) h = lim;
    if (h < -lim) h = -lim;
    if (h > 32767) h = 32767;
    if (h < -32768) h = -32768;
    r.heading = h[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // scoreboard: record accepted transactions, check results in order
  always @(posedge clk) begin
    heading_res_t got;
    heading_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (row_fixed)
          pending_headings.push_back(row_res);
        else
          pending_headings.push_back(predict_heading({in_x_high_byte, in_x_low_byte},
                                                     {in_z_high_byte, in_z_low_byte}));
      end
      if (out_valid && !out_stall) begin
        got.heading   = out_heading_deg_q7;
        got.both_zero = out_both_zero;
        if (pending_headings.size() == 0) begin
          report_mismatch($sformatf("unexpected result heading=%h both_zero=%b",
                                    got.heading, got.both_zero));
        end else begin
          want = pending_headings.pop_front();
          if (got.heading !== want.heading)
            report_mismatch($sformatf("heading got %h want %h", got.heading, want.heading));
          if (got.both_zero !== want.both_zero)
            report_mismatch($sformatf("both_zero got %b want %b",
                                      got.both_zero, want.both_zero));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // entered and left at a falling edge; valid stays high on return
  task automatic send_sample(input logic [15:0] xv, input logic [15:0] zv,
                             input logic fixed, input heading_res_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_x_high_byte <= xv[15:8];
    in_x_low_byte  <= xv[7:0];
    in_z_high_byte <= zv[15:8];
    in_z_low_byte  <= zv[7:0];
    row_fixed      <= fixed;
    row_res        <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] xv;
    logic [15:0] zv;
    int          mode;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_x_high_byte <= 8'h00;
    in_x_low_byte  <= 8'h00;
    in_z_high_byte <= 8'h00;
    in_z_low_byte  <= 8'h00;
    row_fixed      <= 1'b0;
    row_res        <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_sample(dir_rows[i].x, dir_rows[i].z, dir_rows[i].fixed, dir_rows[i].res);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        mode = $urandom_range(9);
        xv   = 16'($urandom);
        zv   = 16'($urandom);
        case (mode)
          4: begin
            xv = 16'($urandom_range(8)) - 16'd4;
            zv = 16'($urandom_range(8)) - 16'd4;
          end
          5: if ($urandom_range(1)) xv = 16'h0000; else zv = 16'h0000;
          6: begin xv = 16'h0000; zv = 16'h0000; end
          7: begin xv = xv | 16'h8000; zv = 16'h0000; end
          8: begin
            xv[15:8] = $urandom_range(1) ? 8'h7F : 8'h80;
            zv[15:8] = $urandom_range(1) ? 8'h7F : 8'h80;
          end
          9: zv = $urandom_range(1) ? xv : -xv;
          default: ;
        endcase
        send_sample(xv, zv, 1'b0, '0);
      end
      // hold the sender off until the pipeline is empty
      drain_results();
    end

    repeat (LATENCY + 5) @(posedge clk);
    if (pending_headings.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_headings.size()));
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
